FILE: rtl/bsie_pkg.sv
package bsie_pkg;

  // default stack depth
  localparam int unsigned DEPTH_DEF = 32;

  // fixed field widths
  localparam int unsigned DW  = 8;
  localparam int unsigned CNW = 6;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // engine status seen by the top level
  typedef struct packed {
    logic             idle;
    logic             done;
    status_t          status;
    logic [CNW-1:0]   count;
    logic [DW-1:0]    top_value;
  } core_stat_t;

endpackage

FILE: rtl/bsie_core.sv
module bsie_core #(
  parameter int unsigned DEPTH = bsie_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                command,
  input  logic [bsie_pkg::DW-1:0]   key,
  input  logic [bsie_pkg::DW-1:0]   value,
  input  logic                      take,
  output bsie_pkg::core_stat_t      stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_UP   = 7'b0000100,
    S_INS  = 7'b0001000,
    S_DN   = 7'b0010000,
    S_TOP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                   state, state_next;
  logic [CW-1:0]            fill, fill_next;
  logic [bsie_pkg::DW-1:0]  top, top_next;
  bsie_pkg::cmd_t           cmd, cmd_next;
  logic [bsie_pkg::DW-1:0]  key_r, key_next;
  logic [bsie_pkg::DW-1:0]  val_r, val_next;
  logic [AW-1:0]            chk, chk_next;
  logic [CW-1:0]            left, left_next;
  logic [AW-1:0]            src, src_next;
  logic [AW-1:0]            pos, pos_next;
  bsie_pkg::status_t        status, status_next;

  logic [bsie_pkg::DW-1:0]  mem [DEPTH];
  logic [bsie_pkg::DW-1:0]  rdata;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [bsie_pkg::DW-1:0]  wdata;

  logic          full, empty, hit;
  logic [AW-1:0] fill_m1, fill_m2;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign fill_m1 = AW'(fill - CW'(1));
  assign fill_m2 = AW'(fill - CW'(2));
  assign hit     = (rdata == key_r);

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    top_next    = top;
    cmd_next    = cmd;
    key_next    = key_r;
    val_next    = val_r;
    chk_next    = chk;
    left_next   = left;
    src_next    = src;
    pos_next    = pos;
    status_next = status;
    raddr       = fill_m1;
    we          = 1'b0;
    waddr       = fill_m1;
    wdata       = val_r;
    case (state)
      S_IDLE: begin
        if (start && (bsie_pkg::cmd_t'(command) == bsie_pkg::CMD_POP)) begin
          raddr = fill_m2;
        end
        if (start) begin
          cmd_next    = bsie_pkg::cmd_t'(command);
          key_next    = key;
          val_next    = value;
          chk_next    = fill_m1;
          left_next   = fill;
          status_next = bsie_pkg::ST_OK;
          state_next  = S_DONE;
          case (bsie_pkg::cmd_t'(command))
            bsie_pkg::CMD_PUSH: begin
              if (full) begin
                status_next = bsie_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = AW'(fill);
                wdata     = value;
                fill_next = fill + CW'(1);
                top_next  = value;
              end
            end
            bsie_pkg::CMD_POP: begin
              if (empty) begin
                status_next = bsie_pkg::ST_EMPTY;
              end else begin
                fill_next = fill - CW'(1);
                if (fill == CW'(1)) begin
                  top_next = '0;
                end else begin
                  state_next = S_TOP;
                end
              end
            end
            bsie_pkg::CMD_INSERT: begin
              if (empty) begin
                status_next = bsie_pkg::ST_EMPTY;
              end else if (full) begin
                status_next = bsie_pkg::ST_FULL;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              if (empty) begin
                status_next = bsie_pkg::ST_EMPTY;
              end else begin
                state_next = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // rdata holds entry chk, next lower entry is being read
        raddr = chk - AW'(1);
        if (hit) begin
          pos_next    = chk;
          status_next = bsie_pkg::ST_OK;
          if (cmd == bsie_pkg::CMD_INSERT) begin
            if (chk == fill_m1) begin
              // key is the top entry: new value goes straight on top
              we         = 1'b1;
              waddr      = AW'(fill);
              wdata      = val_r;
              fill_next  = fill + CW'(1);
              top_next   = val_r;
              state_next = S_DONE;
            end else begin
              raddr      = fill_m1;
              src_next   = fill_m1;
              state_next = S_UP;
            end
          end else begin
            if (chk == fill_m1) begin
              fill_next = fill - CW'(1);
              if (fill == CW'(1)) begin
                top_next   = '0;
                state_next = S_DONE;
              end else begin
                raddr      = fill_m2;
                state_next = S_TOP;
              end
            end else begin
              raddr      = chk + AW'(1);
              src_next   = chk + AW'(1);
              state_next = S_DN;
            end
          end
        end else if (left == CW'(1)) begin
          status_next = bsie_pkg::ST_NOTFOUND;
          state_next  = S_DONE;
        end else begin
          chk_next  = chk - AW'(1);
          left_next = left - CW'(1);
        end
      end
      S_UP: begin
        // move entry src up by one, read the one below
        we    = 1'b1;
        waddr = src + AW'(1);
        wdata = rdata;
        raddr = src - AW'(1);
        if (src == pos + AW'(1)) begin
          state_next = S_INS;
        end else begin
          src_next = src - AW'(1);
        end
      end
      S_INS: begin
        we         = 1'b1;
        waddr      = pos + AW'(1);
        wdata      = val_r;
        fill_next  = fill + CW'(1);
        state_next = S_DONE;
      end
      S_DN: begin
        // move entry src down by one, read the one above
        we    = 1'b1;
        waddr = src - AW'(1);
        wdata = rdata;
        raddr = src + AW'(1);
        if (src == fill_m1) begin
          fill_next  = fill - CW'(1);
          state_next = S_DONE;
        end else begin
          src_next = src + AW'(1);
        end
      end
      S_TOP: begin
        top_next   = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      top   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      top   <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    key_r  <= key_next;
    val_r  <= val_next;
    chk    <= chk_next;
    left   <= left_next;
    src    <= src_next;
    pos    <= pos_next;
    status <= status_next;
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.done      = (state == S_DONE);
  assign stat.status    = status;
  assign stat.count     = bsie_pkg::CNW'(fill);
  assign stat.top_value = empty ? '0 : top;

endmodule

FILE: rtl/byte_stack_insert_remove_engine_unit.sv
// channel | handshake            | payload
// --------+----------------------+----------------------------------
// in      | in_valid / in_ready  | command[1:0], key[7:0], value[7:0]
// out     | out_valid / out_ready| status[1:0], count[5:0], top_value[7:0]
//
// one transaction at a time, one memory read port; push, up-front refusals and a
// pop that empties the stack finish at once, other pops reload the new top; insert
// scans for the key, shifts the entries above it up and writes the value (only the
// write with the key on top), remove scans, then shifts down or reloads the top
// synchronous rst empties the stack, memory contents are not cleared
// a waiting result blocks only the completion of the next transaction
module byte_stack_insert_remove_engine_unit #(
  parameter int unsigned DEPTH = bsie_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [bsie_pkg::DW-1:0]    key,
  input  logic [bsie_pkg::DW-1:0]    value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [bsie_pkg::CNW-1:0]   count,
  output logic [bsie_pkg::DW-1:0]    top_value
);

  bsie_pkg::core_stat_t stat;
  logic                 start;
  logic                 take;

  // engine is ready only when idle
  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;

  // move a finished result into the output register when it is free
  assign take = stat.done && (!out_valid || out_ready);

  bsie_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .key     (key),
    .value   (value),
    .take    (take),
    .stat    (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, loaded with each result
  always_ff @(posedge clk) begin
    if (take) begin
      status    <= stat.status;
      count     <= stat.count;
      top_value <= stat.top_value;
    end
  end

endmodule

FILE: rtl/bsie_checker.sv
module bsie_checker #(
  parameter int unsigned DEPTH = bsie_pkg::DEPTH_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic [bsie_pkg::CNW-1:0]  count,
  input logic [bsie_pkg::DW-1:0]   top_value
);

  // engine takes one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // an empty stack reports zero as its top
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count == '0) && (DEPTH < 64) |-> top_value == '0)
    else $error("non-zero top on empty stack");

  // full and empty status agree with the count
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((status != bsie_pkg::ST_EMPTY) || (count == '0)) &&
      ((status != bsie_pkg::ST_FULL) || (count == bsie_pkg::CNW'(DEPTH))))
    else $error("status disagrees with count");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(count) && $stable(top_value))
    else $error("stalled result changed");

endmodule

bind byte_stack_insert_remove_engine_unit bsie_checker #(.DEPTH(DEPTH)) u_bsie_checker (.*);

FILE: tb/tb_byte_stack_insert_remove_engine_unit.sv
module tb_byte_stack_insert_remove_engine_unit;
  // self-checking bench for the byte stack engine
  // commands go in one transaction at a time through issue_command, which also
  // updates a local copy of the stack and queues the result it should produce;
  // a monitor on the output channel compares every result transaction, field by
  // field, against the oldest queued prediction

  localparam int unsigned STACK_DEPTH = bsie_pkg::DEPTH_DEF;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  // settle time after the last result, above the worst scan-and-shift time
  localparam int unsigned TAIL_CYCLES = 2 * STACK_DEPTH + 10;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    bsie_pkg::status_t        status;
    logic [bsie_pkg::CNW-1:0] count;
    logic [bsie_pkg::DW-1:0]  top_value;
  } stack_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               command;
  logic [bsie_pkg::DW-1:0]  key;
  logic [bsie_pkg::DW-1:0]  value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic [bsie_pkg::CNW-1:0] count;
  logic [bsie_pkg::DW-1:0]  top_value;

  // local picture of the stack: slot fill-1 is the top, slot 0 the bottom
  logic [bsie_pkg::DW-1:0]  stack_bytes [STACK_DEPTH];
  int unsigned              stack_fill;

  stack_result_t  pending_results [$];
  int unsigned    error_count;
  int unsigned    stall_cycles;
  bit             idle_on;

  byte_stack_insert_remove_engine_unit #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .key      (key),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .count    (count),
    .top_value(top_value)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // stack predictor
  // ---------------------------------------------------------------------

  // topmost slot holding k, or -1 when k is not on the stack
  function automatic int find_from_top(logic [bsie_pkg::DW-1:0] k);
    int i;
    for (i = int'(stack_fill) - 1; i >= 0; i--) begin
      if (stack_bytes[i] == k) return i;
    end
    return -1;
  endfunction

  // applies one command to the local stack and returns the result it gives
  function automatic stack_result_t apply_stack_command(bsie_pkg::cmd_t c,
                                                        logic [bsie_pkg::DW-1:0] k,
                                                        logic [bsie_pkg::DW-1:0] v);
    stack_result_t r;
    int            pos;
    int            i;
    r.status = bsie_pkg::ST_OK;
    case (c)
      bsie_pkg::CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.status = bsie_pkg::ST_FULL;
        end else begin
          stack_bytes[stack_fill] = v;
          stack_fill++;
        end
      end
      bsie_pkg::CMD_POP: begin
        if (stack_fill == 0) r.status = bsie_pkg::ST_EMPTY;
        else stack_fill--;
      end
      bsie_pkg::CMD_INSERT: begin
        // full is checked ahead of the search
        if (stack_fill == 0) begin
          r.status = bsie_pkg::ST_EMPTY;
        end else if (stack_fill >= STACK_DEPTH) begin
          r.status = bsie_pkg::ST_FULL;
        end else begin
          pos = find_from_top(k);
          if (pos < 0) begin
            r.status = bsie_pkg::ST_NOTFOUND;
          end else begin
            // new byte lands just above the match, everything above moves up
            for (i = int'(stack_fill); i > pos + 1; i--) stack_bytes[i] = stack_bytes[i-1];
            stack_bytes[pos+1] = v;
            stack_fill++;
          end
        end
      end
      default: begin
        if (stack_fill == 0) begin
          r.status = bsie_pkg::ST_EMPTY;
        end else begin
          pos = find_from_top(k);
          if (pos < 0) begin
            r.status = bsie_pkg::ST_NOTFOUND;
          end else begin
            for (i = pos; i < int'(stack_fill) - 1; i++) stack_bytes[i] = stack_bytes[i+1];
            stack_fill--;
          end
        end
      end
    endcase
    r.count     = stack_fill[bsie_pkg::CNW-1:0];
    r.top_value = (stack_fill == 0) ? '0 : stack_bytes[stack_fill-1];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // presents one command at the falling edge and holds it until the
  // transaction completes; valid is left high so back-to-back commands
  // need no gap
  task automatic issue_command(bsie_pkg::cmd_t c, logic [bsie_pkg::DW-1:0] k,
                               logic [bsie_pkg::DW-1:0] v);
    @(negedge clk);
    // random idle cycles with valid low
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    command  = c;
    key      = k;
    value    = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_stack_command(c, k, v));
  endtask

  // drops valid and waits for every queued prediction to be answered
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic bit holds_byte(logic [bsie_pkg::DW-1:0] k);
    return find_from_top(k) >= 0;
  endfunction

  // a byte that is nowhere on the stack, starting from a random point
  function automatic logic [bsie_pkg::DW-1:0] absent_byte();
    logic [bsie_pkg::DW-1:0] k;
    k = bsie_pkg::DW'($urandom_range(255));
    while (holds_byte(k)) k++;
    return k;
  endfunction

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // receiver stalls at random, about 6 percent of the time, while idling is on
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !(idle_on && $urandom_range(99) < 6);
  end

  // result monitor
  always @(posedge clk) begin : check_result
    stack_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result transaction: status %0d count %0d top %02h",
                   status, count, top_value);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || count !== want.count ||
            top_value !== want.top_value) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected st %0d cnt %0d top %02h, got st %0d cnt %0d top %02h",
                     want.status, want.count, want.top_value, status, count, top_value);
        end
      end
    end
  end

  // watchdog on cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // every command against an empty stack, then a push popped straight back
  task automatic test_empty_stack();
    issue_command(bsie_pkg::CMD_POP,    8'h00, 8'h00);
    issue_command(bsie_pkg::CMD_REMOVE, 8'hFF, 8'h00);
    issue_command(bsie_pkg::CMD_INSERT, 8'h00, 8'hFF);
    issue_command(bsie_pkg::CMD_PUSH,   8'h00, 8'h3C);
    issue_command(bsie_pkg::CMD_POP,    8'hFF, 8'hFF);
    drain_results();
  endtask

  // field extremes, insert at top and bottom, remove at top, middle and bottom, misses,
  // and duplicate keys where the topmost match must win
  task automatic test_insert_remove_cases();
    issue_command(bsie_pkg::CMD_PUSH,   8'hFF, 8'h00);
    issue_command(bsie_pkg::CMD_PUSH,   8'h00, 8'hFF);
    issue_command(bsie_pkg::CMD_INSERT, 8'hFF, 8'h80);  // match at the top
    issue_command(bsie_pkg::CMD_INSERT, 8'h00, 8'h7F);  // match at the bottom
    issue_command(bsie_pkg::CMD_INSERT, 8'h55, 8'hAA);  // key missing
    issue_command(bsie_pkg::CMD_PUSH,   8'h00, 8'hA5);
    issue_command(bsie_pkg::CMD_PUSH,   8'h00, 8'hA5);
    issue_command(bsie_pkg::CMD_INSERT, 8'hA5, 8'h01);  // duplicate, topmost copy taken
    issue_command(bsie_pkg::CMD_REMOVE, 8'hA5, 8'h00);  // removes the upper copy
    issue_command(bsie_pkg::CMD_REMOVE, 8'h00, 8'h00);  // bottom entry
    issue_command(bsie_pkg::CMD_REMOVE, 8'hFF, 8'h00);  // middle entry
    issue_command(bsie_pkg::CMD_REMOVE, 8'h55, 8'h00);  // key missing
    issue_command(bsie_pkg::CMD_REMOVE, 8'h01, 8'hFF);  // top entry
    issue_command(bsie_pkg::CMD_POP,    8'h00, 8'h00);
    issue_command(bsie_pkg::CMD_POP,    8'h00, 8'h00);
    issue_command(bsie_pkg::CMD_POP,    8'h00, 8'h00);  // pops the last entry
    drain_results();
  endtask

  // refusals on a full stack, then a refill through insert and a full unwind
  task automatic test_full_stack();
    while (stack_fill < STACK_DEPTH)
      issue_command(bsie_pkg::CMD_PUSH, bsie_pkg::DW'($urandom_range(255)),
                    bsie_pkg::DW'($urandom_range(255)));
    issue_command(bsie_pkg::CMD_PUSH,   8'h00, bsie_pkg::DW'($urandom_range(255)));
    issue_command(bsie_pkg::CMD_INSERT, stack_bytes[0], 8'h5A); // key present, still full
    issue_command(bsie_pkg::CMD_INSERT, absent_byte(), 8'hA5);  // key absent, full wins
    issue_command(bsie_pkg::CMD_REMOVE, stack_bytes[5], 8'h00);
    issue_command(bsie_pkg::CMD_INSERT, stack_bytes[0], 8'hFF); // back to full
    issue_command(bsie_pkg::CMD_REMOVE, absent_byte(), 8'h00);
    while (stack_fill > 0)
      issue_command(bsie_pkg::CMD_POP, bsie_pkg::DW'($urandom_range(255)),
                    bsie_pkg::DW'($urandom_range(255)));
    drain_results();
  endtask

  // weighted random commands; blocks of forty alternate between growing and
  // shrinking the stack so it swings between empty and full; keys mostly
  // come from the stack so searches hit, with some fully random noise
  task automatic test_random_traffic(int unsigned items, bit with_idle);
    int unsigned             n;
    int unsigned             pick;
    bit                      grow;
    bsie_pkg::cmd_t          c;
    logic [bsie_pkg::DW-1:0] k;
    idle_on = with_idle;
    for (n = 0; n < items; n++) begin
      grow = ((n / 40) % 2) == 0;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 10) begin
        c = bsie_pkg::cmd_t'($urandom_range(3));
      end else if (grow) begin
        c = (pick < 35) ? bsie_pkg::CMD_PUSH :
            (pick < 70) ? bsie_pkg::CMD_INSERT :
            (pick < 80) ? bsie_pkg::CMD_POP : bsie_pkg::CMD_REMOVE;
      end else begin
        c = (pick < 10) ? bsie_pkg::CMD_PUSH :
            (pick < 30) ? bsie_pkg::CMD_INSERT :
            (pick < 65) ? bsie_pkg::CMD_POP : bsie_pkg::CMD_REMOVE;
      end
      if (stack_fill > 0 && $urandom_range(99) < 80)
        k = stack_bytes[$urandom_range(stack_fill - 1)];
      else
        k = bsie_pkg::DW'($urandom_range(255));
      issue_command(c, k, bsie_pkg::DW'($urandom_range(255)));
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = bsie_pkg::CMD_PUSH;
    key         = '0;
    value       = '0;
    out_ready   = 1'b0;
    stack_fill  = 0;
    error_count = 0;
    stall_cycles = 0;
    idle_on     = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_insert_remove_cases();
    test_full_stack();
    test_random_traffic(250, 1'b1);
    // long stretch with both sides always ready
    test_random_traffic(150, 1'b0);
    test_random_traffic(250, 1'b1);

    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
